/* rtl/mrb_pkg.sv */
// Shared constants, codes and types of the Modbus register bank.
// No dependencies; used by modbus_register_bank_unit, the checker and the testbench.
`default_nettype none

package mrb_pkg;

    localparam int COIL_COUNT     = 256;
    localparam int DISCRETE_COUNT = 256;
    localparam int HOLDING_COUNT  = 128;
    localparam int INPUT_COUNT    = 128;

    localparam int COIL_AW     = $clog2(COIL_COUNT);
    localparam int DISCRETE_AW = $clog2(DISCRETE_COUNT);
    localparam int HOLDING_AW  = $clog2(HOLDING_COUNT);
    localparam int INPUT_AW    = $clog2(INPUT_COUNT);

    localparam int CLR_DEPTH_A = (COIL_COUNT > DISCRETE_COUNT) ? COIL_COUNT : DISCRETE_COUNT;
    localparam int CLR_DEPTH_B = (HOLDING_COUNT > INPUT_COUNT) ? HOLDING_COUNT : INPUT_COUNT;
    localparam int CLR_DEPTH   = (CLR_DEPTH_A > CLR_DEPTH_B) ? CLR_DEPTH_A : CLR_DEPTH_B;
    localparam int CLR_AW      = $clog2(CLR_DEPTH);

    localparam int MAX_BIT_QTY     = 2000;
    localparam int MAX_READ_WORDS  = 125;
    localparam int MAX_WRITE_WORDS = 123;
    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    localparam int BIT_CHUNK  = 64;
    localparam int WORD_CHUNK = 4;

    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_RD_COILS  = 4'd0;
    localparam cmd_t CMD_RD_DISC   = 4'd1;
    localparam cmd_t CMD_RD_INPUT  = 4'd2;
    localparam cmd_t CMD_RD_HOLD   = 4'd3;
    localparam cmd_t CMD_WR_COIL   = 4'd4;
    localparam cmd_t CMD_WR_COILS  = 4'd5;
    localparam cmd_t CMD_WR_HOLD   = 4'd6;
    localparam cmd_t CMD_WR_HOLDS  = 4'd7;
    localparam cmd_t CMD_PAYLOAD   = 4'd8;
    localparam cmd_t CMD_SET_DISC  = 4'd9;
    localparam cmd_t CMD_SET_INPUT = 4'd10;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_EXC    = 3'd0;
    localparam kind_t KIND_COUNT  = 3'd1;
    localparam kind_t KIND_CHUNK  = 3'd2;
    localparam kind_t KIND_ECHO   = 3'd3;
    localparam kind_t KIND_ACK    = 3'd4;
    localparam kind_t KIND_NOTIFY = 3'd5;

    localparam logic ERR_ADDR  = 1'b0;
    localparam logic ERR_VALUE = 1'b1;
    localparam logic TGT_COIL  = 1'b0;
    localparam logic TGT_HOLD  = 1'b1;

    typedef logic [1:0] pend_t;
    localparam pend_t PEND_NONE  = 2'd0;
    localparam pend_t PEND_COILS = 2'd1;
    localparam pend_t PEND_HOLD  = 2'd2;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_COILS     = 2'd0;
    localparam reg_idx_t REG_DISCRETES = 2'd1;
    localparam reg_idx_t REG_HOLDING   = 2'd2;
    localparam reg_idx_t REG_INPUTS    = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic        error_code;
        logic [15:0] index;
        logic        target;
        logic [63:0] data;
        logic        last;
    } result_t;

    function automatic result_t mk_res(kind_t k, logic e, logic [15:0] i, logic t,
                                       logic [63:0] d, logic l);
        result_t r;
        r.kind       = k;
        r.error_code = e;
        r.index      = i;
        r.target     = t;
        r.data       = d;
        r.last       = l;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/mrb_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/modbus_register_bank_unit.sv */
// Modbus slave register bank: request sequencer, four store memories, APB registers.
// Depends on mrb_pkg and mrb_ram.
//
// After reset a clearing pass zeroes the store memories; no request is taken until
// it ends (APB writes are taken at any time). A request is first captured, then
// gives its results one at a time. Reads go through the stores one element a cycle
// from a one-element-wide memory port; at the end of each chunk the read waits
// until the chunk result can be given. A coil payload byte writes up to eight
// coils with one result per bit; the last byte is followed by an acknowledgement.
`default_nettype none

module modbus_register_bank_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [15:0] quantity,
    input  wire logic [7:0]  byte_count,
    input  wire logic [15:0] value,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic             error_code,
    output logic [15:0]      index,
    output logic             target,
    output logic [63:0]      data,
    output logic             last,
    // APB
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_ECHO, S_PAY_BITS, S_ACK, S_READ
    } state_t;

    state_t state_reg, state_next;
    logic [mrb_pkg::CLR_AW-1:0] clr_reg, clr_next;

    logic [8:0] coils_in_use_reg, discretes_in_use_reg;
    logic [7:0] holding_in_use_reg, inputs_in_use_reg;

    mrb_pkg::cmd_t cmd_reg, cmd_next;
    logic [15:0] addr_reg, addr_next, qty_reg, qty_next, val_reg, val_next;
    logic [7:0]  bc_reg, bc_next;

    logic             out_valid_reg, out_valid_next;
    mrb_pkg::result_t res_reg, res_next;

    mrb_pkg::pend_t pend_mode_reg, pend_mode_next;
    logic [15:0] pend_addr_reg, pend_addr_next, pend_cur_reg, pend_cur_next;
    logic [11:0] pend_rem_reg, pend_rem_next, pend_qty_reg, pend_qty_next;
    logic [2:0]  pb_reg, pb_next;

    logic [15:0] cur_reg, cur_next, rem_reg, rem_next, chunk_idx_reg, chunk_idx_next;
    logic [6:0]  ib_reg, ib_next;
    logic [63:0] word_reg, word_next;
    logic        acc_v_reg, acc_v_next;
    logic [5:0]  acc_pos_reg, acc_pos_next;

    logic                           coil_we, disc_we, hold_we, inp_we;
    logic [mrb_pkg::COIL_AW-1:0]     coil_waddr;
    logic [mrb_pkg::DISCRETE_AW-1:0] disc_waddr;
    logic [mrb_pkg::HOLDING_AW-1:0]  hold_waddr;
    logic [mrb_pkg::INPUT_AW-1:0]    inp_waddr;
    logic        coil_wdata, disc_wdata;
    logic [15:0] hold_wdata, inp_wdata;
    logic        coil_rdata, disc_rdata;
    logic [15:0] hold_rdata, inp_rdata;

    logic [16:0] nc, nd, nh, ni, rd_size, sum;
    logic        slot_free, bits_bad, words_bad, coils_wr_bad, holds_wr_bad;
    logic        bit_read, issue, rbit;
    logic [15:0] rword;
    logic [6:0]  chunk_cap;
    logic        cfg_wr;

    mrb_ram #(.WIDTH(1), .DEPTH(mrb_pkg::COIL_COUNT)) u_coil_ram (
        .clk(clk), .we(coil_we), .waddr(coil_waddr), .wdata(coil_wdata),
        .raddr(cur_reg[mrb_pkg::COIL_AW-1:0]), .rdata(coil_rdata)
    );
    mrb_ram #(.WIDTH(1), .DEPTH(mrb_pkg::DISCRETE_COUNT)) u_disc_ram (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
        .raddr(cur_reg[mrb_pkg::DISCRETE_AW-1:0]), .rdata(disc_rdata)
    );
    mrb_ram #(.WIDTH(16), .DEPTH(mrb_pkg::HOLDING_COUNT)) u_hold_ram (
        .clk(clk), .we(hold_we), .waddr(hold_waddr), .wdata(hold_wdata),
        .raddr(cur_reg[mrb_pkg::HOLDING_AW-1:0]), .rdata(hold_rdata)
    );
    mrb_ram #(.WIDTH(16), .DEPTH(mrb_pkg::INPUT_COUNT)) u_inp_ram (
        .clk(clk), .we(inp_we), .waddr(inp_waddr), .wdata(inp_wdata),
        .raddr(cur_reg[mrb_pkg::INPUT_AW-1:0]), .rdata(inp_rdata)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            mrb_pkg::REG_COILS:     prdata = {23'b0, coils_in_use_reg};
            mrb_pkg::REG_DISCRETES: prdata = {23'b0, discretes_in_use_reg};
            mrb_pkg::REG_HOLDING:   prdata = {24'b0, holding_in_use_reg};
            mrb_pkg::REG_INPUTS:    prdata = {24'b0, inputs_in_use_reg};
            default:                prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coils_in_use_reg     <= 9'd256;
            discretes_in_use_reg <= 9'd256;
            holding_in_use_reg   <= 8'd128;
            inputs_in_use_reg    <= 8'd128;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                mrb_pkg::REG_COILS:     coils_in_use_reg     <= pwdata[8:0];
                mrb_pkg::REG_DISCRETES: discretes_in_use_reg <= pwdata[8:0];
                mrb_pkg::REG_HOLDING:   holding_in_use_reg   <= pwdata[7:0];
                mrb_pkg::REG_INPUTS:    inputs_in_use_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    assign nc = (17'(coils_in_use_reg) > 17'(mrb_pkg::COIL_COUNT)) ?
                17'(mrb_pkg::COIL_COUNT) : 17'(coils_in_use_reg);
    assign nd = (17'(discretes_in_use_reg) > 17'(mrb_pkg::DISCRETE_COUNT)) ?
                17'(mrb_pkg::DISCRETE_COUNT) : 17'(discretes_in_use_reg);
    assign nh = (17'(holding_in_use_reg) > 17'(mrb_pkg::HOLDING_COUNT)) ?
                17'(mrb_pkg::HOLDING_COUNT) : 17'(holding_in_use_reg);
    assign ni = (17'(inputs_in_use_reg) > 17'(mrb_pkg::INPUT_COUNT)) ?
                17'(mrb_pkg::INPUT_COUNT) : 17'(inputs_in_use_reg);

    always_comb
    begin
        unique case (cmd_reg)
            mrb_pkg::CMD_RD_COILS: rd_size = nc;
            mrb_pkg::CMD_RD_DISC:  rd_size = nd;
            mrb_pkg::CMD_RD_INPUT: rd_size = ni;
            default:               rd_size = nh;
        endcase
    end

    assign sum          = 17'(addr_reg) + 17'(qty_reg);
    assign bits_bad     = (qty_reg == 16'd0) || (qty_reg > 16'(mrb_pkg::MAX_BIT_QTY)) ||
                          (sum > rd_size);
    assign words_bad    = (qty_reg == 16'd0) || (qty_reg > 16'(mrb_pkg::MAX_READ_WORDS)) ||
                          (sum > rd_size);
    assign coils_wr_bad = (qty_reg == 16'd0) || (qty_reg > 16'(mrb_pkg::MAX_BIT_QTY)) ||
                          (sum > nc) || (17'(bc_reg) != ((17'(qty_reg) + 17'd7) >> 3));
    assign holds_wr_bad = (qty_reg == 16'd0) || (qty_reg > 16'(mrb_pkg::MAX_WRITE_WORDS)) ||
                          (sum > nh) || (17'(bc_reg) != {qty_reg, 1'b0});

    assign slot_free = !out_valid_reg || !out_stall;
    assign bit_read  = (cmd_reg == mrb_pkg::CMD_RD_COILS) || (cmd_reg == mrb_pkg::CMD_RD_DISC);
    assign chunk_cap = bit_read ? 7'(mrb_pkg::BIT_CHUNK) : 7'(mrb_pkg::WORD_CHUNK);
    assign issue     = (ib_reg != chunk_cap) && (rem_reg != 16'd0);
    assign rbit      = (cmd_reg == mrb_pkg::CMD_RD_COILS) ? coil_rdata : disc_rdata;
    assign rword     = (cmd_reg == mrb_pkg::CMD_RD_INPUT) ? inp_rdata : hold_rdata;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign kind       = res_reg.kind;
    assign error_code = res_reg.error_code;
    assign index      = res_reg.index;
    assign target     = res_reg.target;
    assign data       = res_reg.data;
    assign last       = res_reg.last;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        qty_next       = qty_reg;
        bc_next        = bc_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        pend_mode_next = pend_mode_reg;
        pend_addr_next = pend_addr_reg;
        pend_cur_next  = pend_cur_reg;
        pend_rem_next  = pend_rem_reg;
        pend_qty_next  = pend_qty_reg;
        pb_next        = pb_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        chunk_idx_next = chunk_idx_reg;
        ib_next        = ib_reg;
        word_next      = word_reg;
        acc_v_next     = 1'b0;
        acc_pos_next   = acc_pos_reg;

        coil_we    = 1'b0;
        disc_we    = 1'b0;
        hold_we    = 1'b0;
        inp_we     = 1'b0;
        coil_waddr = addr_reg[mrb_pkg::COIL_AW-1:0];
        disc_waddr = addr_reg[mrb_pkg::DISCRETE_AW-1:0];
        hold_waddr = addr_reg[mrb_pkg::HOLDING_AW-1:0];
        inp_waddr  = addr_reg[mrb_pkg::INPUT_AW-1:0];
        coil_wdata = 1'b0;
        disc_wdata = 1'b0;
        hold_wdata = val_reg;
        inp_wdata  = val_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                coil_we    = 32'(clr_reg) < mrb_pkg::COIL_COUNT;
                disc_we    = 32'(clr_reg) < mrb_pkg::DISCRETE_COUNT;
                hold_we    = 32'(clr_reg) < mrb_pkg::HOLDING_COUNT;
                inp_we     = 32'(clr_reg) < mrb_pkg::INPUT_COUNT;
                coil_waddr = mrb_pkg::COIL_AW'(clr_reg);
                disc_waddr = mrb_pkg::DISCRETE_AW'(clr_reg);
                hold_waddr = mrb_pkg::HOLDING_AW'(clr_reg);
                inp_waddr  = mrb_pkg::INPUT_AW'(clr_reg);
                hold_wdata = 16'd0;
                inp_wdata  = 16'd0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == mrb_pkg::CLR_AW'(mrb_pkg::CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    addr_next  = address;
                    qty_next   = quantity;
                    bc_next    = byte_count;
                    val_next   = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                    if (cmd_reg <= mrb_pkg::CMD_WR_HOLDS)
                    begin
                        pend_mode_next = mrb_pkg::PEND_NONE;
                        pend_addr_next = 16'd0;
                        pend_rem_next  = 12'd0;
                        pend_qty_next  = 12'd0;
                    end
                    unique case (cmd_reg) inside
                        mrb_pkg::CMD_RD_COILS, mrb_pkg::CMD_RD_DISC,
                        mrb_pkg::CMD_RD_INPUT, mrb_pkg::CMD_RD_HOLD:
                        begin
                            out_valid_next = 1'b1;
                            if (bit_read ? bits_bad : words_bad)
                            begin
                                res_next = mrb_pkg::mk_res(mrb_pkg::KIND_EXC, mrb_pkg::ERR_ADDR,
                                    addr_reg, mrb_pkg::TGT_COIL, 64'd0, 1'b1);
                            end
                            else
                            begin
                                res_next = mrb_pkg::mk_res(mrb_pkg::KIND_COUNT,
                                    mrb_pkg::ERR_ADDR, addr_reg, mrb_pkg::TGT_COIL,
                                    bit_read ? 64'((17'(qty_reg) + 17'd7) >> 3)
                                             : 64'({qty_reg, 1'b0}), 1'b0);
                                cur_next       = addr_reg;
                                rem_next       = qty_reg;
                                chunk_idx_next = addr_reg;
                                ib_next        = 7'd0;
                                word_next      = 64'd0;
                                state_next     = S_READ;
                            end
                        end
                        mrb_pkg::CMD_WR_COIL:
                        begin
                            out_valid_next = 1'b1;
                            if (17'(addr_reg) >= nc)
                            begin
                                res_next = mrb_pkg::mk_res(mrb_pkg::KIND_EXC, mrb_pkg::ERR_ADDR,
                                    addr_reg, mrb_pkg::TGT_COIL, 64'd0, 1'b1);
                            end
                            else if (val_reg != mrb_pkg::COIL_OFF && val_reg != mrb_pkg::COIL_ON)
                            begin
                                res_next = mrb_pkg::mk_res(mrb_pkg::KIND_EXC, mrb_pkg::ERR_VALUE,
                                    addr_reg, mrb_pkg::TGT_COIL, 64'd0, 1'b1);
                            end
                            else
                            begin
                                coil_we    = 1'b1;
                                coil_wdata = (val_reg == mrb_pkg::COIL_ON);
                                res_next   = mrb_pkg::mk_res(mrb_pkg::KIND_NOTIFY,
                                    mrb_pkg::ERR_ADDR, addr_reg, mrb_pkg::TGT_COIL,
                                    64'(val_reg == mrb_pkg::COIL_ON), 1'b0);
                                state_next = S_ECHO;
                            end
                        end
                        mrb_pkg::CMD_WR_HOLD:
                        begin
                            out_valid_next = 1'b1;
                            if (17'(addr_reg) >= nh)
                            begin
                                res_next = mrb_pkg::mk_res(mrb_pkg::KIND_EXC, mrb_pkg::ERR_ADDR,
                                    addr_reg, mrb_pkg::TGT_COIL, 64'd0, 1'b1);
                            end
                            else
                            begin
                                hold_we    = 1'b1;
                                res_next   = mrb_pkg::mk_res(mrb_pkg::KIND_NOTIFY,
                                    mrb_pkg::ERR_ADDR, addr_reg, mrb_pkg::TGT_HOLD,
                                    64'(val_reg), 1'b0);
                                state_next = S_ECHO;
                            end
                        end
                        mrb_pkg::CMD_WR_COILS, mrb_pkg::CMD_WR_HOLDS:
                        begin
                            if ((cmd_reg == mrb_pkg::CMD_WR_COILS) ? coils_wr_bad : holds_wr_bad)
                            begin
                                out_valid_next = 1'b1;
                                res_next = mrb_pkg::mk_res(mrb_pkg::KIND_EXC, mrb_pkg::ERR_ADDR,
                                    addr_reg, mrb_pkg::TGT_COIL, 64'd0, 1'b1);
                            end
                            else
                            begin
                                pend_mode_next = (cmd_reg == mrb_pkg::CMD_WR_COILS) ?
                                                 mrb_pkg::PEND_COILS : mrb_pkg::PEND_HOLD;
                                pend_addr_next = addr_reg;
                                pend_cur_next  = addr_reg;
                                pend_rem_next  = qty_reg[11:0];
                                pend_qty_next  = qty_reg[11:0];
                            end
                        end
                        mrb_pkg::CMD_PAYLOAD:
                        begin
                            if (pend_mode_reg == mrb_pkg::PEND_COILS)
                            begin
                                pb_next    = 3'd0;
                                state_next = S_PAY_BITS;
                            end
                            else if (pend_mode_reg == mrb_pkg::PEND_HOLD)
                            begin
                                hold_we        = 17'(pend_cur_reg) < 17'(mrb_pkg::HOLDING_COUNT);
                                hold_waddr     = pend_cur_reg[mrb_pkg::HOLDING_AW-1:0];
                                out_valid_next = 1'b1;
                                res_next       = mrb_pkg::mk_res(mrb_pkg::KIND_NOTIFY,
                                    mrb_pkg::ERR_ADDR, pend_cur_reg, mrb_pkg::TGT_HOLD,
                                    64'(val_reg), pend_rem_reg != 12'd1);
                                pend_rem_next  = pend_rem_reg - 1'b1;
                                pend_cur_next  = pend_cur_reg + 1'b1;
                                if (pend_rem_reg == 12'd1)
                                begin
                                    state_next = S_ACK;
                                end
                            end
                        end
                        mrb_pkg::CMD_SET_DISC:
                        begin
                            disc_we    = 17'(addr_reg) < 17'(mrb_pkg::DISCRETE_COUNT);
                            disc_wdata = (val_reg != 16'd0);
                        end
                        mrb_pkg::CMD_SET_INPUT:
                        begin
                            inp_we = 17'(addr_reg) < 17'(mrb_pkg::INPUT_COUNT);
                        end
                        default: ;
                    endcase
                end
            end

            S_ECHO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    res_next = mrb_pkg::mk_res(mrb_pkg::KIND_ECHO, mrb_pkg::ERR_ADDR, addr_reg,
                        (cmd_reg == mrb_pkg::CMD_WR_HOLD) ? mrb_pkg::TGT_HOLD : mrb_pkg::TGT_COIL,
                        64'(val_reg), 1'b1);
                    state_next = S_IDLE;
                end
            end

            S_PAY_BITS:
            begin
                if (slot_free)
                begin
                    coil_we        = 17'(pend_cur_reg) < 17'(mrb_pkg::COIL_COUNT);
                    coil_waddr     = pend_cur_reg[mrb_pkg::COIL_AW-1:0];
                    coil_wdata     = val_reg[pb_reg];
                    out_valid_next = 1'b1;
                    res_next       = mrb_pkg::mk_res(mrb_pkg::KIND_NOTIFY, mrb_pkg::ERR_ADDR,
                        pend_cur_reg, mrb_pkg::TGT_COIL, 64'(val_reg[pb_reg]),
                        (pb_reg == 3'd7) && (pend_rem_reg != 12'd1));
                    pend_rem_next  = pend_rem_reg - 1'b1;
                    pend_cur_next  = pend_cur_reg + 1'b1;
                    pb_next        = pb_reg + 1'b1;
                    if (pend_rem_reg == 12'd1)
                    begin
                        state_next = S_ACK;
                    end
                    else if (pb_reg == 3'd7)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_ACK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    res_next = mrb_pkg::mk_res(mrb_pkg::KIND_ACK, mrb_pkg::ERR_ADDR,
                        pend_addr_reg,
                        (pend_mode_reg == mrb_pkg::PEND_HOLD) ? mrb_pkg::TGT_HOLD
                                                              : mrb_pkg::TGT_COIL,
                        64'(pend_qty_reg), 1'b1);
                    pend_mode_next = mrb_pkg::PEND_NONE;
                    pend_addr_next = 16'd0;
                    pend_qty_next  = 12'd0;
                    state_next     = S_IDLE;
                end
            end

            S_READ:
            begin
                if (acc_v_reg)
                begin
                    word_next = bit_read ? (word_reg | (64'(rbit) << acc_pos_reg))
                                         : (word_reg | (64'(rword) << {acc_pos_reg[1:0], 4'b0}));
                end
                if (issue)
                begin
                    acc_v_next   = 1'b1;
                    acc_pos_next = ib_reg[5:0];
                    cur_next     = cur_reg + 1'b1;
                    rem_next     = rem_reg - 1'b1;
                    ib_next      = ib_reg + 1'b1;
                end
                else if (!acc_v_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    res_next = mrb_pkg::mk_res(mrb_pkg::KIND_CHUNK, mrb_pkg::ERR_ADDR,
                        chunk_idx_reg, mrb_pkg::TGT_COIL, word_reg, rem_reg == 16'd0);
                    ib_next        = 7'd0;
                    word_next      = 64'd0;
                    chunk_idx_next = cur_reg;
                    if (rem_reg == 16'd0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_mode_reg <= mrb_pkg::PEND_NONE;
            pend_addr_reg <= 16'd0;
            pend_cur_reg  <= 16'd0;
            pend_rem_reg  <= 12'd0;
            pend_qty_reg  <= 12'd0;
            acc_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            pend_mode_reg <= pend_mode_next;
            pend_addr_reg <= pend_addr_next;
            pend_cur_reg  <= pend_cur_next;
            pend_rem_reg  <= pend_rem_next;
            pend_qty_reg  <= pend_qty_next;
            acc_v_reg     <= acc_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        qty_reg       <= qty_next;
        bc_reg        <= bc_next;
        val_reg       <= val_next;
        res_reg       <= res_next;
        pb_reg        <= pb_next;
        cur_reg       <= cur_next;
        rem_reg       <= rem_next;
        chunk_idx_reg <= chunk_idx_next;
        ib_reg        <= ib_next;
        word_reg      <= word_next;
        acc_pos_reg   <= acc_pos_next;
    end

endmodule

`default_nettype wire

/* tb/modbus_register_bank_check.sv */
// Checker for modbus_register_bank_unit: watches the request, result and APB ports,
// predicts the results of every accepted request and compares them in order.
// Depends on mrb_pkg.
module modbus_register_bank_check
    import mrb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [3:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [15:0] quantity,
    input  wire logic [7:0]  byte_count,
    input  wire logic [15:0] value,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  kind,
    input  wire logic        error_code,
    input  wire logic [15:0] index,
    input  wire logic        target,
    input  wire logic [63:0] data,
    input  wire logic        last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               outstanding,
    output int               results_checked
);

    logic        coil_bits [COIL_COUNT];
    logic        disc_bits [DISCRETE_COUNT];
    logic [15:0] hold_words [HOLDING_COUNT];
    logic [15:0] input_words [INPUT_COUNT];
    int          coils_size, discs_size, hold_size, inputs_size;
    pend_t       pend_mode;
    int          pend_addr, pend_left, pend_qty;

    result_t     batch [$];
    result_t     expected_results [$];

    function automatic int clamp(int sz, int cap);
        return sz < cap ? sz : cap;
    endfunction

    function automatic void add(kind_t k, logic e, int i, logic t, logic [63:0] d);
        result_t r;
        r.kind       = k;
        r.error_code = e;
        r.index      = i[15:0];
        r.target     = t;
        r.data       = d;
        r.last       = 1'b0;
        batch.push_back(r);
    endfunction

    function automatic void bad_address(int a);
        add(KIND_EXC, ERR_ADDR, a, TGT_COIL, '0);
    endfunction

    function automatic void read_bit_run(bit disc, int sz, int a, int q);
        logic [63:0] w;
        if (q == 0 || q > MAX_BIT_QTY || a + q > sz)
        begin
            bad_address(a);
            return;
        end
        add(KIND_COUNT, ERR_ADDR, a, TGT_COIL, (q + 7) / 8);
        for (int off = 0; off < q; off += BIT_CHUNK)
        begin
            w = '0;
            for (int b = 0; b < BIT_CHUNK && off + b < q; b++)
                w[b] = disc ? disc_bits[a + off + b] : coil_bits[a + off + b];
            add(KIND_CHUNK, ERR_ADDR, a + off, TGT_COIL, w);
        end
    endfunction

    function automatic void read_word_run(bit hold, int sz, int a, int q);
        logic [63:0] w;
        if (q == 0 || q > MAX_READ_WORDS || a + q > sz)
        begin
            bad_address(a);
            return;
        end
        add(KIND_COUNT, ERR_ADDR, a, TGT_COIL, q * 2);
        for (int off = 0; off < q; off += WORD_CHUNK)
        begin
            w = '0;
            for (int k = 0; k < WORD_CHUNK && off + k < q; k++)
                w[16*k +: 16] = hold ? hold_words[a + off + k] : input_words[a + off + k];
            add(KIND_CHUNK, ERR_ADDR, a + off, TGT_COIL, w);
        end
    endfunction

    function automatic void apply_payload(logic [15:0] v);
        int idx;
        if (pend_mode == PEND_COILS)
        begin
            for (int b = 0; b < 8 && pend_left > 0; b++)
            begin
                idx = pend_addr + pend_qty - pend_left;
                if (idx < COIL_COUNT)
                    coil_bits[idx] = v[b];
                add(KIND_NOTIFY, ERR_ADDR, idx, TGT_COIL, v[b]);
                pend_left--;
            end
        end
        else if (pend_mode == PEND_HOLD)
        begin
            if (pend_left > 0)
            begin
                idx = pend_addr + pend_qty - pend_left;
                if (idx < HOLDING_COUNT)
                    hold_words[idx] = v;
                add(KIND_NOTIFY, ERR_ADDR, idx, TGT_HOLD, v);
                pend_left--;
            end
        end
        else
            return;
        if (pend_left == 0)
        begin
            add(KIND_ACK, ERR_ADDR, pend_addr,
                pend_mode == PEND_HOLD ? TGT_HOLD : TGT_COIL, pend_qty);
            pend_mode = PEND_NONE;
            pend_addr = 0;
            pend_qty  = 0;
        end
    endfunction

    function automatic void serve_request(logic [3:0] c, int a, int q, int bc,
                                          logic [15:0] v);
        int nc, nh;
        nc = clamp(coils_size, COIL_COUNT);
        nh = clamp(hold_size, HOLDING_COUNT);
        batch.delete();
        if (c <= CMD_WR_HOLDS)
        begin
            pend_mode = PEND_NONE;
            pend_addr = 0;
            pend_left = 0;
            pend_qty  = 0;
        end
        case (c)
            CMD_RD_COILS:  read_bit_run(1'b0, nc, a, q);
            CMD_RD_DISC:   read_bit_run(1'b1, clamp(discs_size, DISCRETE_COUNT), a, q);
            CMD_RD_INPUT:  read_word_run(1'b0, clamp(inputs_size, INPUT_COUNT), a, q);
            CMD_RD_HOLD:   read_word_run(1'b1, nh, a, q);
            CMD_WR_COIL:
                if (a >= nc)
                    bad_address(a);
                else if (v != COIL_OFF && v != COIL_ON)
                    add(KIND_EXC, ERR_VALUE, a, TGT_COIL, '0);
                else
                begin
                    coil_bits[a] = (v == COIL_ON);
                    add(KIND_NOTIFY, ERR_ADDR, a, TGT_COIL, v == COIL_ON);
                    add(KIND_ECHO, ERR_ADDR, a, TGT_COIL, v);
                end
            CMD_WR_COILS:
                if (q == 0 || q > MAX_BIT_QTY || a + q > nc || bc != (q + 7) / 8)
                    bad_address(a);
                else
                begin
                    pend_mode = PEND_COILS;
                    pend_addr = a;
                    pend_left = q;
                    pend_qty  = q;
                end
            CMD_WR_HOLD:
                if (a >= nh)
                    bad_address(a);
                else
                begin
                    hold_words[a] = v;
                    add(KIND_NOTIFY, ERR_ADDR, a, TGT_HOLD, v);
                    add(KIND_ECHO, ERR_ADDR, a, TGT_HOLD, v);
                end
            CMD_WR_HOLDS:
                if (q == 0 || q > MAX_WRITE_WORDS || a + q > nh || bc != q * 2)
                    bad_address(a);
                else
                begin
                    pend_mode = PEND_HOLD;
                    pend_addr = a;
                    pend_left = q;
                    pend_qty  = q;
                end
            CMD_PAYLOAD:   apply_payload(v);
            CMD_SET_DISC:  if (a < DISCRETE_COUNT) disc_bits[a] = (v != 0);
            CMD_SET_INPUT: if (a < INPUT_COUNT) input_words[a] = v;
            default: ;
        endcase
        if (batch.size() > 0)
            batch[$].last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endfunction

    function automatic void compare_result();
        result_t exp_r;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result kind=%0d index=%0d data=%h", $time,
                     kind, index, data);
            fail_count++;
            return;
        end
        exp_r = expected_results.pop_front();
        results_checked++;
        if (exp_r.kind != kind || exp_r.error_code != error_code
            || exp_r.index != index || exp_r.target != target
            || exp_r.data != data || exp_r.last != last)
        begin
            $display("%0t: result mismatch expected kind=%0d err=%0d idx=%0d tgt=%0d data=%h last=%0d",
                     $time, exp_r.kind, exp_r.error_code, exp_r.index, exp_r.target,
                     exp_r.data, exp_r.last);
            $display("%0t:                 actual kind=%0d err=%0d idx=%0d tgt=%0d data=%h last=%0d",
                     $time, kind, error_code, index, target, data, last);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count      = 0;
        results_checked = 0;
        outstanding     = 0;
        foreach (coil_bits[i])   coil_bits[i]   = 1'b0;
        foreach (disc_bits[i])   disc_bits[i]   = 1'b0;
        foreach (hold_words[i])  hold_words[i]  = '0;
        foreach (input_words[i]) input_words[i] = '0;
        coils_size  = 256;
        discs_size  = 256;
        hold_size   = 128;
        inputs_size = 128;
        pend_mode   = PEND_NONE;
        pend_addr   = 0;
        pend_left   = 0;
        pend_qty    = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
                case (reg_idx_t'(paddr[3:2]))
                    REG_COILS:     coils_size  = pwdata[8:0];
                    REG_DISCRETES: discs_size  = pwdata[8:0];
                    REG_HOLDING:   hold_size   = pwdata[7:0];
                    REG_INPUTS:    inputs_size = pwdata[7:0];
                endcase
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall)
                serve_request(command, address, quantity, byte_count, value);
            outstanding = expected_results.size();
        end
    end

endmodule

/* tb/modbus_register_bank_unit_test.sv */
// Testbench top for modbus_register_bank_unit: drives requests, APB writes and
// result-side stalls, and reports the verdict. Depends on mrb_pkg, the unit and the checker.
module modbus_register_bank_unit_test;
    import mrb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  command;
    logic [15:0] address;
    logic [15:0] quantity;
    logic [7:0]  byte_count;
    logic [15:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic        error_code;
    logic [15:0] index;
    logic        target;
    logic [63:0] data;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, outstanding, results_checked;
    int cycles;
    int requests_sent;
    bit quiet;
    bit long_hold;
    int cfg_coils, cfg_discs, cfg_hold, cfg_inputs;

    modbus_register_bank_unit u_dut (.*);

    modbus_register_bank_check u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles,
                         outstanding);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stall bursts, or a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(logic [3:0] c, int a, int q, int bc, int v);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= c;
        address    <= a[15:0];
        quantity   <= q[15:0];
        byte_count <= bc[7:0];
        value      <= v[15:0];
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic apb_write(reg_idx_t r, int v);
        wait_drained();
        repeat (60) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_sizes(int c, int d, int h, int i);
        cfg_coils  = c;
        cfg_discs  = d;
        cfg_hold   = h;
        cfg_inputs = i;
        apb_write(REG_COILS, c);
        apb_write(REG_DISCRETES, d);
        apb_write(REG_HOLDING, h);
        apb_write(REG_INPUTS, i);
    endtask

    function automatic int lesser(int a, int b);
        return a < b ? a : b;
    endfunction

    task automatic random_request();
        int pick, sz, a, q, bc, n;
        logic [3:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            c  = $urandom_range(0, 3);
            sz = c == CMD_RD_COILS ? lesser(cfg_coils, COIL_COUNT)
               : c == CMD_RD_DISC  ? lesser(cfg_discs, DISCRETE_COUNT)
               : c == CMD_RD_INPUT ? lesser(cfg_inputs, INPUT_COUNT)
               : lesser(cfg_hold, HOLDING_COUNT);
            q = $urandom_range(1, c <= CMD_RD_DISC ? 80 : 20);
            if (sz > 0)
                q = lesser(q, sz);
            a = sz >= q ? $urandom_range(0, sz - q) : $urandom_range(0, 300);
            if ($urandom_range(0, 9) == 0)
            begin
                a = $urandom;
                q = $urandom;
            end
            send(c, a, q, $urandom, $urandom);
        end
        else if (pick < 40)
        begin
            a = $urandom_range(0, lesser(cfg_coils, COIL_COUNT) + 2);
            n = $urandom_range(0, 5);
            send(CMD_WR_COIL, a, $urandom, $urandom,
                 n < 2 ? COIL_ON : n < 4 ? COIL_OFF : $urandom);
        end
        else if (pick < 50)
        begin
            a = $urandom_range(0, lesser(cfg_hold, HOLDING_COUNT) + 2);
            if ($urandom_range(0, 9) == 0)
                a = $urandom;
            send(CMD_WR_HOLD, a, $urandom, $urandom, $urandom);
        end
        else if (pick < 75)
        begin
            c  = $urandom_range(0, 1) ? CMD_WR_COILS : CMD_WR_HOLDS;
            sz = c == CMD_WR_COILS ? lesser(cfg_coils, COIL_COUNT)
                                   : lesser(cfg_hold, HOLDING_COUNT);
            q  = $urandom_range(1, c == CMD_WR_COILS ? 24 : 6);
            if (sz > 0)
                q = lesser(q, sz);
            a  = sz >= q ? $urandom_range(0, sz - q) : $urandom_range(0, 300);
            bc = c == CMD_WR_COILS ? (q + 7) / 8 : q * 2;
            if ($urandom_range(0, 9) == 0)
                bc = $urandom;
            send(c, a, q, bc, $urandom);
            n = c == CMD_WR_COILS ? (q + 7) / 8 : q;
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(0, n + 1);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(CMD_SET_INPUT, $urandom_range(0, 130), $urandom, $urandom, $urandom);
                send(CMD_PAYLOAD, $urandom, $urandom, $urandom, $urandom);
            end
        end
        else if (pick < 90)
        begin
            c = $urandom_range(0, 1) ? CMD_SET_DISC : CMD_SET_INPUT;
            a = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 255);
            send(c, a, $urandom, $urandom, $urandom_range(0, 3) == 0 ? 0 : $urandom);
        end
        else if (pick < 95)
            send(CMD_PAYLOAD, $urandom, $urandom, $urandom, $urandom);
        else
            send($urandom_range(11, 15), $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = '0;
        address    = '0;
        quantity   = '0;
        byte_count = '0;
        value      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        quiet      = 1'b0;
        long_hold  = 1'b0;
        requests_sent = 0;
        cfg_coils  = 256;
        cfg_discs  = 256;
        cfg_hold   = 128;
        cfg_inputs = 128;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send(CMD_RD_COILS, 0, 256, 0, 0);
        send(CMD_RD_COILS, 0, 0, 0, 0);
        send(CMD_RD_COILS, 0, 2001, 0, 0);
        send(CMD_RD_DISC, 16'hFFFF, 1, 0, 0);
        send(CMD_SET_DISC, 5, 0, 0, 3);
        send(CMD_SET_DISC, 300, 0, 0, 1);
        send(CMD_SET_INPUT, 127, 0, 0, 16'hFFFF);
        send(CMD_SET_INPUT, 16'hFFFF, 0, 0, 16'h1234);
        send(CMD_RD_DISC, 0, 8, 0, 0);
        send(CMD_RD_INPUT, 124, 4, 0, 0);
        send(CMD_RD_INPUT, 0, 126, 0, 0);
        send(CMD_WR_COIL, 3, 0, 0, COIL_ON);
        send(CMD_WR_COIL, 3, 0, 0, 16'h1234);
        send(CMD_WR_COIL, 256, 0, 0, 16'h1234);
        send(CMD_WR_HOLD, 127, 0, 0, 16'hABCD);
        send(CMD_WR_HOLD, 128, 0, 0, 16'hABCD);
        send(CMD_RD_HOLD, 3, 125, 0, 0);
        send(CMD_WR_COILS, 250, 6, 1, 0);
        send(CMD_PAYLOAD, 0, 0, 0, 16'hFFA5);
        send(CMD_WR_COILS, 10, 10, 3, 0);
        send(CMD_WR_HOLDS, 0, 2, 4, 0);
        send(CMD_PAYLOAD, 0, 0, 0, 16'h5A5A);
        send(CMD_SET_DISC, 255, 0, 0, 1);
        send(CMD_PAYLOAD, 0, 0, 0, 16'h8001);
        send(CMD_WR_HOLDS, 4, 3, 6, 0);
        send(CMD_RD_HOLD, 0, 8, 0, 0);
        send(CMD_PAYLOAD, 0, 0, 0, 16'h7777);
        send(4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);

        // receiver holds off while a series of reads is sent
        long_hold = 1'b1;
        for (int k = 0; k < 10; k++)
            send(CMD_RD_COILS, 0, 64, 0, 0);
        wait_drained();

        set_sizes(0, 0, 0, 0);
        for (int k = 0; k < 20; k++)
            random_request();
        set_sizes(511, 511, 255, 255);
        for (int k = 0; k < 60; k++)
            random_request();
        set_sizes($urandom_range(8, 255), $urandom_range(8, 255),
                  $urandom_range(4, 127), $urandom_range(4, 127));
        for (int k = 0; k < 50; k++)
            random_request();
        set_sizes(256, 256, 128, 128);
        while (requests_sent < 250)
            random_request();
        quiet = 1'b1;
        for (int k = 0; k < 10; k++)
            random_request();
        wait_drained();
        repeat (100) @(posedge clk);

        $display("%0d requests sent, %0d results checked over five size settings",
                 requests_sent, results_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
